### rtl/u8dec_pkg.sv
`timescale 1ns / 1ps
package u8dec_pkg;

  localparam int unsigned StepW = 5;
  typedef logic [StepW-1:0] step_t;

  // Source of the result loaded into the output register
  typedef enum logic [2:0] {
    E_NONE = 3'd0,
    E_LEAD = 3'd1,
    E_HELD = 3'd2,
    E_BYTE = 3'd3,
    E_ACC  = 3'd4,
    E_BARE = 3'd5
  } emit_e;

  // How final_res is set on an emitted result
  typedef enum logic [1:0] {
    FN_ZERO  = 2'd0,
    FN_END   = 2'd1,
    FN_FLUSH = 2'd2
  } fin_e;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_FETCH     = 3'd1,
    OP_START     = 3'd2,
    OP_HOLD      = 3'd3,
    OP_IDLE      = 3'd4,
    OP_ACC_INIT  = 3'd5,
    OP_ACC_SHIFT = 3'd6,
    OP_IDX_INC   = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT     = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NOT_PEND = 4'd2,
    C_ASM      = 4'd3,
    C_HOLD     = 4'd4,
    C_NO_HELD  = 4'd5,
    C_MORE     = 4'd6,
    C_BRK      = 4'd7,
    C_ZE       = 4'd8,
    C_LEAD_OK  = 4'd9
  } cond_e;

  typedef struct packed {
    emit_e emit;
    fin_e  fin;
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic can_emit;
    logic not_pend;
    logic asm_ok;
    logic hold;
    logic no_held;
    logic more;
    logic brk;
    logic ze;
    logic lead_ok;
  } status_t;

  localparam step_t S_FETCH      = 5'd0;
  localparam step_t S_DISP       = 5'd1;
  localparam step_t S_DISP_ASM   = 5'd2;
  localparam step_t S_DISP_HOLD  = 5'd3;
  localparam step_t S_FL_LEAD    = 5'd4;
  localparam step_t S_FL_HELD    = 5'd5;
  localparam step_t S_FL_END     = 5'd6;
  localparam step_t S_BAD_BYTE   = 5'd7;
  localparam step_t S_AFTER_BRK  = 5'd8;
  localparam step_t S_FRESH      = 5'd9;
  localparam step_t S_FRESH_LEAD = 5'd10;
  localparam step_t S_RAW        = 5'd11;
  localparam step_t S_START      = 5'd12;
  localparam step_t S_BARE       = 5'd13;
  localparam step_t S_ASM        = 5'd14;
  localparam step_t S_ASM_SHIFT  = 5'd15;
  localparam step_t S_ASM_EMIT   = 5'd16;
  localparam step_t S_HOLD       = 5'd17;

  function automatic ctrl_t uw(input emit_e e, input fin_e f, input op_e o,
                               input cond_e c, input step_t t);
    ctrl_t w;
    w.emit   = e;
    w.fin    = f;
    w.op     = o;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Microprogram: one control word per step
  function automatic ctrl_t ucode(input step_t a);
    ctrl_t w;
    w = uw(E_NONE, FN_ZERO, OP_NOP, C_ALWAYS, S_FETCH);
    unique case (a)
      S_FETCH:      w = uw(E_NONE, FN_ZERO,  OP_FETCH,     C_NEXT,     S_FETCH);
      S_DISP:       w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_NOT_PEND, S_FRESH);
      S_DISP_ASM:   w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_ASM,      S_ASM);
      S_DISP_HOLD:  w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_HOLD,     S_HOLD);
      S_FL_LEAD:    w = uw(E_LEAD, FN_FLUSH, OP_NOP,       C_NO_HELD,  S_FL_END);
      S_FL_HELD:    w = uw(E_HELD, FN_FLUSH, OP_IDX_INC,   C_MORE,     S_FL_HELD);
      S_FL_END:     w = uw(E_NONE, FN_ZERO,  OP_IDLE,      C_BRK,      S_AFTER_BRK);
      S_BAD_BYTE:   w = uw(E_BYTE, FN_END,   OP_NOP,       C_ALWAYS,   S_FETCH);
      S_AFTER_BRK:  w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_ZE,       S_FETCH);
      S_FRESH:      w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_ZE,       S_BARE);
      S_FRESH_LEAD: w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_LEAD_OK,  S_START);
      S_RAW:        w = uw(E_BYTE, FN_END,   OP_NOP,       C_ALWAYS,   S_FETCH);
      S_START:      w = uw(E_NONE, FN_ZERO,  OP_START,     C_ALWAYS,   S_FETCH);
      S_BARE:       w = uw(E_BARE, FN_END,   OP_NOP,       C_ALWAYS,   S_FETCH);
      S_ASM:        w = uw(E_NONE, FN_ZERO,  OP_ACC_INIT,  C_NO_HELD,  S_ASM_EMIT);
      S_ASM_SHIFT:  w = uw(E_NONE, FN_ZERO,  OP_ACC_SHIFT, C_MORE,     S_ASM_SHIFT);
      S_ASM_EMIT:   w = uw(E_ACC,  FN_END,   OP_IDLE,      C_ALWAYS,   S_FETCH);
      S_HOLD:       w = uw(E_NONE, FN_ZERO,  OP_HOLD,      C_ALWAYS,   S_FETCH);
      default:      w = uw(E_NONE, FN_ZERO,  OP_NOP,       C_ALWAYS,   S_FETCH);
    endcase
    return w;
  endfunction

endpackage

### rtl/utf8_to_ucs4_stream_decoder.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     in_valid_i / in_stall_o  byte_in_i[7:0], end_of_text_i
// output    out_valid_o / out_stall_i code_point_o[30:0], has_char_o, final_res_o
// config    cfg_we_i                cfg_wdata_i (zero_ends_text)
//
// One byte is in work at a time: after a byte is fetched, the microprogram holds
// it, starts a sequence, emits it directly, emits a bare end marker, assembles a
// character from the held bytes, or flushes the held bytes of a broken sequence,
// before the next byte is taken.
// An output stall holds the microprogram only on steps that emit. The output register lets the
// next byte be taken while the last result still waits.
// Reset clears the sequence state and sets zero_ends_text to 1.
module utf8_to_ucs4_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] code_point_o,
  output logic        has_char_o,
  output logic        final_res_o
);

  u8dec_pkg::ctrl_t   ctrl;
  u8dec_pkg::status_t st;
  logic               exec;

  u8dec_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .ctrl_o (ctrl),
    .exec_o (exec)
  );

  u8dec_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .byte_in_i     (byte_in_i),
    .end_of_text_i (end_of_text_i),
    .out_stall_i   (out_stall_i),
    .ctrl_i        (ctrl),
    .exec_i        (exec),
    .st_o          (st),
    .out_valid_o   (out_valid_o),
    .code_point_o  (code_point_o),
    .has_char_o    (has_char_o),
    .final_res_o   (final_res_o)
  );

  // Take a transfer only on the fetch step
  assign in_stall_o = ctrl.op != u8dec_pkg::OP_FETCH;

endmodule

### rtl/u8dec_seq.sv
`timescale 1ns / 1ps
module u8dec_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8dec_pkg::status_t st_i,
  output u8dec_pkg::ctrl_t   ctrl_o,
  output logic               exec_o
);

  u8dec_pkg::step_t step_q, step_d;
  u8dec_pkg::ctrl_t uw;
  logic             jump;

  assign uw = u8dec_pkg::ucode(step_q);

  always_comb begin
    unique case (uw.cond)
      u8dec_pkg::C_NEXT:     jump = 1'b0;
      u8dec_pkg::C_ALWAYS:   jump = 1'b1;
      u8dec_pkg::C_NOT_PEND: jump = st_i.not_pend;
      u8dec_pkg::C_ASM:      jump = st_i.asm_ok;
      u8dec_pkg::C_HOLD:     jump = st_i.hold;
      u8dec_pkg::C_NO_HELD:  jump = st_i.no_held;
      u8dec_pkg::C_MORE:     jump = st_i.more;
      u8dec_pkg::C_BRK:      jump = st_i.brk;
      u8dec_pkg::C_ZE:       jump = st_i.ze;
      u8dec_pkg::C_LEAD_OK:  jump = st_i.lead_ok;
      default:               jump = 1'b1;
    endcase
  end

  // Hold the step until its transfer can happen
  always_comb begin
    if (uw.op == u8dec_pkg::OP_FETCH) begin
      exec_o = st_i.in_valid;
    end else begin
      exec_o = (uw.emit == u8dec_pkg::E_NONE) || st_i.can_emit;
    end
    step_d = step_q;
    if (exec_o) begin
      step_d = jump ? uw.target : u8dec_pkg::step_t'(step_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= u8dec_pkg::S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = uw;

endmodule

### rtl/u8dec_dp.sv
`timescale 1ns / 1ps
module u8dec_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic [7:0]         byte_in_i,
  input  logic               end_of_text_i,
  input  logic               out_stall_i,
  input  u8dec_pkg::ctrl_t   ctrl_i,
  input  logic               exec_i,
  output u8dec_pkg::status_t st_o,
  output logic               out_valid_o,
  output logic [30:0]        code_point_o,
  output logic               has_char_o,
  output logic               final_res_o
);

  localparam int unsigned HeldDepth = 5;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    priority if ((b & 8'hE0) == 8'hC0) r = 3'd2;
    else if ((b & 8'hF0) == 8'hE0)     r = 3'd3;
    else if ((b & 8'hF8) == 8'hF0)     r = 3'd4;
    else if ((b & 8'hFC) == 8'hF8)     r = 3'd5;
    else                               r = 3'd6;
    return r;
  endfunction

  function automatic logic overlong(input logic [7:0] lead, input logic [2:0] len,
                                    input logic [5:0] c1);
    logic r;
    unique case (len)
      3'd2:    r = lead < 8'hC2;
      3'd3:    r = (c1 < 6'h20) && (lead < 8'hE1);
      3'd4:    r = (c1 < 6'h10) && (lead < 8'hF1);
      3'd5:    r = (c1 < 6'h08) && (lead < 8'hF9);
      default: r = (c1 < 6'h04) && (lead < 8'hFD);
    endcase
    return r;
  endfunction

  logic        ze_cfg_q;
  logic [7:0]  lead_q, lead_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  len_q, len_d;
  logic [5:0]  held_q [HeldDepth];
  logic [2:0]  idx_q;
  logic [30:0] acc_q;
  logic [7:0]  b_q;
  logic        end_q, ze_q, pend_q, brk_q, asm_q, hold_q, lead_ok_q;

  logic        out_valid_q;
  logic [30:0] out_cp_q;
  logic        out_has_q, out_fin_q;

  // Classify the incoming byte against the pending sequence
  logic       zero_end, is_cont, pend, comp, ovl, brk, asm_ok, hold, lead_ok;
  logic [5:0] c1;

  always_comb begin
    zero_end = ze_cfg_q && (byte_in_i == 8'h00);
    is_cont  = (byte_in_i & 8'hC0) == 8'h80;
    pend     = len_q != 3'd0;
    comp     = ({1'b0, cnt_q} + 4'd2) >= {1'b0, len_q};
    c1       = (cnt_q != 3'd0) ? held_q[0] : byte_in_i[5:0];
    ovl      = overlong(lead_q, len_q, c1);
    brk      = pend && (zero_end || !is_cont);
    asm_ok   = pend && !brk && comp && !ovl;
    hold     = pend && !brk && !comp && !end_of_text_i;
    lead_ok  = (byte_in_i >= 8'hC0) && (byte_in_i <= 8'hFD) && !end_of_text_i;
  end

  logic more, no_held, can_emit;
  assign more     = ({1'b0, idx_q} + 4'd1) < {1'b0, cnt_q};
  assign no_held  = cnt_q == 3'd0;
  assign can_emit = !out_valid_q || !out_stall_i;

  always_comb begin
    st_o.in_valid = in_valid_i;
    st_o.can_emit = can_emit;
    st_o.not_pend = !pend_q;
    st_o.asm_ok   = asm_q;
    st_o.hold     = hold_q;
    st_o.no_held  = no_held;
    st_o.more     = more;
    st_o.brk      = brk_q;
    st_o.ze       = ze_q;
    st_o.lead_ok  = lead_ok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ze_cfg_q <= 1'b1;
    end else if (cfg_we_i) begin
      ze_cfg_q <= cfg_wdata_i;
    end
  end

  // Sequence state
  always_comb begin
    lead_d = lead_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    if (exec_i) begin
      unique case (ctrl_i.op)
        u8dec_pkg::OP_START: begin
          lead_d = b_q;
          cnt_d  = 3'd0;
          len_d  = lead_len(b_q);
        end
        u8dec_pkg::OP_HOLD: begin
          cnt_d = cnt_q + 3'd1;
        end
        u8dec_pkg::OP_IDLE: begin
          lead_d = 8'h00;
          cnt_d  = 3'd0;
          len_d  = 3'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'h00;
      cnt_q  <= 3'd0;
      len_q  <= 3'd0;
    end else begin
      lead_q <= lead_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      unique case (ctrl_i.op)
        u8dec_pkg::OP_FETCH: begin
          b_q       <= byte_in_i;
          end_q     <= end_of_text_i || zero_end;
          ze_q      <= zero_end;
          pend_q    <= pend;
          brk_q     <= brk;
          asm_q     <= asm_ok;
          hold_q    <= hold;
          lead_ok_q <= lead_ok;
          idx_q     <= 3'd0;
        end
        u8dec_pkg::OP_HOLD: begin
          held_q[cnt_q] <= b_q[5:0];
        end
        u8dec_pkg::OP_ACC_INIT: begin
          acc_q <= {23'd0, lead_q & (8'h7F >> len_q)};
          idx_q <= 3'd0;
        end
        u8dec_pkg::OP_ACC_SHIFT: begin
          acc_q <= {acc_q[24:0], held_q[idx_q]};
          idx_q <= idx_q + 3'd1;
        end
        u8dec_pkg::OP_IDX_INC: begin
          idx_q <= idx_q + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  logic        emit_now;
  logic [30:0] emit_cp;
  logic        emit_has, emit_fin;

  assign emit_now = exec_i && (ctrl_i.emit != u8dec_pkg::E_NONE);

  always_comb begin
    emit_has = 1'b1;
    unique case (ctrl_i.emit)
      u8dec_pkg::E_LEAD: emit_cp = {23'd0, lead_q};
      u8dec_pkg::E_HELD: emit_cp = {23'd0, 2'b10, held_q[idx_q]};
      u8dec_pkg::E_BYTE: emit_cp = {23'd0, b_q};
      u8dec_pkg::E_ACC:  emit_cp = {acc_q[24:0], b_q[5:0]};
      default: begin
        emit_cp  = 31'd0;
        emit_has = 1'b0;
      end
    endcase
    unique case (ctrl_i.fin)
      u8dec_pkg::FN_END:   emit_fin = end_q;
      u8dec_pkg::FN_FLUSH: emit_fin = ze_q &&
                                      ((ctrl_i.emit == u8dec_pkg::E_LEAD) ? no_held : !more);
      default:             emit_fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_now) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      out_cp_q  <= emit_cp;
      out_has_q <= emit_has;
      out_fin_q <= emit_fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_cp_q;
  assign has_char_o   = out_has_q;
  assign final_res_o  = out_fin_q;

endmodule
